// ----- sv/pcst_pkg.sv -----
// Shared types and constants for the PC call stack tracer.
// No dependencies; imported by every module of the block.
package pcst_pkg;

   // Fixed field widths of the channel payloads
   localparam int CFG_W   = 7;
   localparam int FUNC_W  = 6;
   localparam int DEPTH_W = 6;
   localparam int ADDR_W  = 32;
   localparam int TIME_W  = 48;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_SCAN,
      ST_PROBE,
      ST_SEEK,
      ST_POP,
      ST_PUSH,
      ST_IRQ,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      STATUS_CHANGED  = 2'd0,
      STATUS_UNMAPPED = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_TRACE = 1'b1
   } op_type;

   // One function range entry of the lookup table
   typedef struct packed {
      logic [ADDR_W-1:0] range_start;
      logic [ADDR_W-1:0] range_end;
      logic              is_irq;
   } entry_type;

   // Commands broadcast to every cell of the frame chain
   typedef struct packed {
      logic push;
      logic pop;
      logic probe;
      logic seek;
   } stack_cmd_type;

endpackage

// ----- sv/pc_call_stack_tracer.sv -----
// PC call stack tracer top level: control sequencer, table and frame chain.
// Depends on pcst_pkg, pcst_table and pcst_stack.
// Usage: req_* carries load items (op 0, writes one range table entry) and
// trace items (op 1, one PC sample). An item transfers when req_valid is high
// and req_stall is low. rsp_* carries at most one result per trace item and
// transfers when rsp_valid is high and rsp_stall is low. The user must write
// csr_entries_in_use through csr_valid/csr_ready (always ready) only while the
// block is idle; the block does not enforce this. A trace item walks the range
// table from entry n-1 down at one entry per cycle through the single table
// read port, then the frame chain passes match flags toward the top one cell
// per cycle and pops one frame per cycle. Outcomes of a trace item, with n
// entries searched:
//    a match below the top pops the frames above the matching one,
//    a hit not on the stack pushes its entry (overflow when the stack is full),
//    a match at the top gives no result,
//    an unmapped PC gives an unmapped result (also when n is 0).
// A stalled result waits in an output register and the next item is still
// accepted; the next result then holds in its last cycle until that register frees.
// Reset empties the stack, clears entries_in_use and drops any held result;
// table and frame contents stay undefined until written.
module pc_call_stack_tracer #(
   parameter int TABLE_DEPTH = 64,
   parameter int STACK_DEPTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_op,
   input  logic [5:0]                     req_entry_index,
   input  logic [pcst_pkg::ADDR_W-1:0]    req_range_start,
   input  logic [pcst_pkg::ADDR_W-1:0]    req_range_end,
   input  logic                           req_entry_is_irq,
   input  logic [pcst_pkg::ADDR_W-1:0]    req_pc,
   input  logic [pcst_pkg::TIME_W-1:0]    req_timestamp,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_status,
   output logic [pcst_pkg::ADDR_W-1:0]    rsp_pc_out,
   output logic [pcst_pkg::TIME_W-1:0]    rsp_time_out,
   output logic [pcst_pkg::DEPTH_W-1:0]   rsp_depth,
   output logic [pcst_pkg::FUNC_W-1:0]    rsp_top_function,
   output logic                           rsp_top_is_irq,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [pcst_pkg::CFG_W-1:0]     csr_entries_in_use
);
   import pcst_pkg::*;

   localparam int TIW = $clog2(TABLE_DEPTH);
   localparam int CW  = (TIW + 1 > CFG_W) ? TIW + 1 : CFG_W;
   localparam int DW  = $clog2(STACK_DEPTH + 1);
   localparam int SW  = (DW > DEPTH_W) ? DW : DEPTH_W;
   localparam int FW  = (TIW > FUNC_W) ? TIW : FUNC_W;

   state_type          state_ff;
   state_type          state_in;
   logic [CFG_W-1:0]   cfg_ff;
   logic [ADDR_W-1:0]  pc_ff;
   logic [ADDR_W-1:0]  pc_in;
   logic [TIME_W-1:0]  ts_ff;
   logic [TIME_W-1:0]  ts_in;
   logic [TIW-1:0]     scan_ff;
   logic [TIW-1:0]     scan_in;
   logic [TIW-1:0]     hit_ff;
   logic [TIW-1:0]     hit_in;
   logic [DW-1:0]      count_ff;
   logic [DW-1:0]      count_in;
   status_type         status_ff;
   status_type         status_in;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               rsp_load;
   status_type         rsp_status_ff;
   logic [ADDR_W-1:0]  rsp_pc_ff;
   logic [TIME_W-1:0]  rsp_time_ff;
   logic [DEPTH_W-1:0] rsp_depth_ff;
   logic [DEPTH_W-1:0] rsp_depth_in;
   logic [FUNC_W-1:0]  rsp_top_ff;
   logic [FUNC_W-1:0]  rsp_top_in;
   logic               rsp_irq_ff;
   logic               rsp_irq_in;

   logic               accept;
   logic [CW-1:0]      cfg_wide;
   logic [CW-1:0]      n_wide;
   logic [CW-1:0]      last_wide;
   logic [CW-1:0]      idx_wide;
   logic               wr_en;
   entry_type          wr_data;
   logic [TIW-1:0]     rd_addr;
   entry_type          rd_data;
   logic               pc_hit;
   stack_cmd_type      cmd;
   logic [DW-1:0]      depth;
   logic [TIW-1:0]     top_entry;
   logic               top_mark;
   logic [SW-1:0]      depth_wide;
   logic [FW-1:0]      top_wide;
   logic               stack_empty;
   logic               stack_full;

   // Configuration register, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         cfg_ff <= csr_entries_in_use;
      end
   end

   // Clamp the searched entry count to the table size
   assign cfg_wide  = CW'(cfg_ff);
   assign n_wide    = (cfg_wide > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : cfg_wide;
   assign last_wide = n_wide - CW'(1);
   assign idx_wide  = CW'(req_entry_index);

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   assign wr_data.range_start = req_range_start;
   assign wr_data.range_end   = req_range_end;
   assign wr_data.is_irq      = req_entry_is_irq;

   // Signed range test on the entry read last cycle
   assign pc_hit = ($signed(pc_ff) >= $signed(rd_data.range_start)) &&
                   ($signed(pc_ff) <= $signed(rd_data.range_end));

   assign stack_empty = (depth == '0);
   assign stack_full  = (depth == DW'(STACK_DEPTH));
   assign depth_wide  = SW'(depth);
   assign top_wide    = FW'(top_entry);
   assign rsp_load    = !rsp_valid_ff || !rsp_stall;

   pcst_table #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .TIW         (TIW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_wide[TIW-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pcst_stack #(
      .STACK_DEPTH (STACK_DEPTH),
      .EW          (TIW),
      .DW          (DW)
   ) u_stack (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .key       (hit_ff),
      .depth     (depth),
      .top_entry (top_entry),
      .top_mark  (top_mark)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_op == OP_TRACE)) begin
               state_in = (n_wide == '0) ? ST_IRQ : ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (pc_hit) begin
               state_in = ST_PROBE;
            end else if (scan_ff == '0) begin
               state_in = ST_IRQ;
            end
         end
         ST_PROBE: begin
            state_in = ST_SEEK;
         end
         ST_SEEK: begin
            if (count_ff == depth) begin
               state_in = stack_full ? ST_IRQ : ST_PUSH;
            end else if (top_mark) begin
               state_in = (count_ff == '0) ? ST_IDLE : ST_POP;
            end
         end
         ST_POP: begin
            if (count_ff == DW'(1)) begin
               state_in = ST_IRQ;
            end
         end
         ST_PUSH: begin
            state_in = ST_IRQ;
         end
         ST_IRQ: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath controls and next values
   always_comb begin
      wr_en        = 1'b0;
      rd_addr      = scan_ff;
      cmd          = '0;
      pc_in        = pc_ff;
      ts_in        = ts_ff;
      scan_in      = scan_ff;
      hit_in       = hit_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_depth_in = depth_wide[DEPTH_W-1:0];
      rsp_top_in   = stack_empty ? '0 : top_wide[FUNC_W-1:0];
      rsp_irq_in   = !stack_empty && rd_data.is_irq;
      case (state_ff)
         ST_IDLE: begin
            wr_en = accept && (req_op == OP_LOAD) && (idx_wide < CW'(TABLE_DEPTH));
            if (accept && (req_op == OP_TRACE)) begin
               pc_in     = req_pc;
               ts_in     = req_timestamp;
               scan_in   = last_wide[TIW-1:0];
               status_in = STATUS_UNMAPPED;
            end
         end
         ST_READ: begin
            rd_addr = scan_ff;
         end
         ST_SCAN: begin
            hit_in = scan_ff;
            if (!pc_hit && (scan_ff != '0)) begin
               scan_in = scan_ff - TIW'(1);
               rd_addr = scan_ff - TIW'(1);
            end
         end
         ST_PROBE: begin
            cmd.probe = 1'b1;
            count_in  = '0;
         end
         ST_SEEK: begin
            if (count_ff == depth) begin
               status_in = stack_full ? STATUS_OVERFLOW : STATUS_CHANGED;
            end else if (top_mark) begin
               status_in = STATUS_CHANGED;
            end else begin
               cmd.seek = 1'b1;
               count_in = count_ff + DW'(1);
            end
         end
         ST_POP: begin
            cmd.pop  = 1'b1;
            count_in = count_ff - DW'(1);
         end
         ST_PUSH: begin
            cmd.push = 1'b1;
         end
         ST_IRQ: begin
            rd_addr = top_entry;
         end
         ST_EMIT: begin
            // keep reading the top entry while the result waits
            rd_addr = top_entry;
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers of the item in flight
   always_ff @(posedge clock) begin
      pc_ff     <= pc_in;
      ts_ff     <= ts_in;
      scan_ff   <= scan_in;
      hit_ff    <= hit_in;
      count_ff  <= count_in;
      status_ff <= status_in;
   end

   // Output register, loaded in ST_EMIT when empty or when the held result transfers
   always_ff @(posedge clock) begin
      if ((state_ff == ST_EMIT) && rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_pc_ff     <= pc_ff;
         rsp_time_ff   <= ts_ff;
         rsp_depth_ff  <= rsp_depth_in;
         rsp_top_ff    <= rsp_top_in;
         rsp_irq_ff    <= rsp_irq_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_pc_out       = rsp_pc_ff;
   assign rsp_time_out     = rsp_time_ff;
   assign rsp_depth        = rsp_depth_ff;
   assign rsp_top_function = rsp_top_ff;
   assign rsp_top_is_irq   = rsp_irq_ff;

endmodule

// ----- sv/pcst_table.sv -----
// Function range table: one write port, one registered read port.
// Depends on pcst_pkg for the entry type.
module pcst_table #(
   parameter int TABLE_DEPTH = 64,
   parameter int TIW         = 6
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [TIW-1:0]      wr_addr,
   input  pcst_pkg::entry_type wr_data,
   input  logic [TIW-1:0]      rd_addr,
   output pcst_pkg::entry_type rd_data
);
   import pcst_pkg::*;

   entry_type mem_ff [TABLE_DEPTH];
   entry_type rd_data_ff;

   // Write on load, read one entry per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/pcst_cell.sv -----
// One frame cell of the shadow call stack chain.
// Depends on pcst_pkg for the command struct.
module pcst_cell #(
   parameter int EW = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   input  pcst_pkg::stack_cmd_type cmd,
   input  logic [EW-1:0]           key,
   input  logic                    live,
   input  logic [EW-1:0]           above_entry,
   input  logic [EW-1:0]           below_entry,
   input  logic                    below_mark,
   output logic [EW-1:0]           entry,
   output logic                    mark
);
   import pcst_pkg::*;

   logic [EW-1:0] entry_ff;
   logic [EW-1:0] entry_in;
   logic          mark_ff;
   logic          mark_in;

   // Shift the frame down on push, up on pop
   always_comb begin
      entry_in = entry_ff;
      if (cmd.push) begin
         entry_in = above_entry;
      end else if (cmd.pop) begin
         entry_in = below_entry;
      end
   end

   // Load own match flag, then pass flags toward the top
   always_comb begin
      mark_in = mark_ff;
      if (cmd.probe) begin
         mark_in = live && (entry_ff == key);
      end else if (cmd.seek) begin
         mark_in = below_mark;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_ff <= 1'b0;
      end else begin
         mark_ff <= mark_in;
      end
   end

   assign entry = entry_ff;
   assign mark  = mark_ff;

endmodule

// ----- sv/pcst_stack.sv -----
// Shadow call stack: a chain of frame cells plus the depth counter.
// Depends on pcst_pkg and pcst_cell. Cell 0 holds the top frame.
module pcst_stack #(
   parameter int STACK_DEPTH = 32,
   parameter int EW          = 6,
   parameter int DW          = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   input  pcst_pkg::stack_cmd_type cmd,
   input  logic [EW-1:0]           key,
   output logic [DW-1:0]           depth,
   output logic [EW-1:0]           top_entry,
   output logic                    top_mark
);
   import pcst_pkg::*;

   logic [EW-1:0]          cell_entry [STACK_DEPTH];
   logic [STACK_DEPTH-1:0] cell_mark;
   logic [DW-1:0]          depth_ff;
   logic [DW-1:0]          depth_in;

   // Track the number of live frames
   always_comb begin
      depth_in = depth_ff;
      if (cmd.push) begin
         depth_in = depth_ff + DW'(1);
      end else if (cmd.pop) begin
         depth_in = depth_ff - DW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else begin
         depth_ff <= depth_in;
      end
   end

   // Build the chain, each cell wired to its neighbors
   for (genvar k = 0; k < STACK_DEPTH; k++) begin : g_cell
      logic [EW-1:0] above;
      logic [EW-1:0] below;
      logic          below_mark;
      logic          live;

      if (k == 0) begin : g_top
         assign above = key;
      end else begin : g_inner
         assign above = cell_entry[k-1];
      end

      if (k == STACK_DEPTH - 1) begin : g_bottom
         assign below      = cell_entry[k];
         assign below_mark = 1'b0;
      end else begin : g_upper
         assign below      = cell_entry[k+1];
         assign below_mark = cell_mark[k+1];
      end

      assign live = DW'(k) < depth_ff;

      pcst_cell #(
         .EW (EW)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .key         (key),
         .live        (live),
         .above_entry (above),
         .below_entry (below),
         .below_mark  (below_mark),
         .entry       (cell_entry[k]),
         .mark        (cell_mark[k])
      );
   end

   assign depth     = depth_ff;
   assign top_entry = cell_entry[0];
   assign top_mark  = cell_mark[0];

endmodule

// ----- sv/pcst_checker.sv -----
// Port-level checks for the PC call stack tracer, bound to the top level.
// Depends on pcst_pkg for the status codes.
module pcst_checker #(
   parameter int STACK_DEPTH = 32
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [1:0]                   rsp_status,
   input logic [pcst_pkg::ADDR_W-1:0]  rsp_pc_out,
   input logic [pcst_pkg::TIME_W-1:0]  rsp_time_out,
   input logic [pcst_pkg::DEPTH_W-1:0] rsp_depth,
   input logic [pcst_pkg::FUNC_W-1:0]  rsp_top_function,
   input logic                         rsp_top_is_irq
);
   import pcst_pkg::*;

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable({rsp_status, rsp_pc_out, rsp_time_out,
                                          rsp_depth, rsp_top_function, rsp_top_is_irq}))
      else $error("stalled result changed");

   // Only defined status codes appear
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_CHANGED) || (rsp_status == STATUS_UNMAPPED) ||
                    (rsp_status == STATUS_OVERFLOW))
      else $error("undefined status code");

   // An overflow is reported only with a full stack
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_OVERFLOW) |-> rsp_depth == DEPTH_W'(STACK_DEPTH))
      else $error("overflow reported below full depth");

   // Reset drops any pending result
   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind pc_call_stack_tracer pcst_checker #(
   .STACK_DEPTH (STACK_DEPTH)
) u_pcst_checker (.*);
